// ===== design/stc_pkg.sv =====
package stc_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE    = 3'd0,
        CMD_READ     = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_SWEEP    = 3'd3,
        CMD_LENGTH   = 3'd4,
        CMD_ENVELOPE = 3'd5
    } cmd_t;

    localparam logic [2:0] OFF_SWEEP    = 3'd0;
    localparam logic [2:0] OFF_DUTY     = 3'd1;
    localparam logic [2:0] OFF_ENVELOPE = 3'd2;
    localparam logic [2:0] OFF_FREQ_LO  = 3'd3;
    localparam logic [2:0] OFF_FREQ_HI  = 3'd4;

    localparam logic [11:0] FREQ_LIMIT   = 12'd2047;
    localparam logic [11:0] PERIOD_BASE  = 12'd2048;
    localparam logic [6:0]  LENGTH_FULL  = 7'd64;
    localparam logic [13:0] PERIOD_MAX   = 14'd8192;

    localparam logic [7:0] DUTY_TABLE [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

    typedef struct packed {
        cmd_t       cmd;
        logic [2:0] offset;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [3:0] sample_level;
        logic       channel_on;
    } result_t;

    function automatic logic [7:0] open_bus(input logic [2:0] offset);
        logic [7:0] mask;
        begin
            case (offset)
                OFF_SWEEP:    mask = 8'h80;
                OFF_DUTY:     mask = 8'h3F;
                OFF_ENVELOPE: mask = 8'h00;
                OFF_FREQ_LO:  mask = 8'hFF;
                OFF_FREQ_HI:  mask = 8'hBF;
                default:      mask = 8'hFF;
            endcase
            return mask;
        end
    endfunction

    function automatic logic [13:0] period_reload(input logic [10:0] freq);
        logic [11:0] span;
        begin
            span = PERIOD_BASE - {1'b0, freq};
            return {span, 2'b00};
        end
    endfunction

endpackage

// ===== design/stc_sweep_calc.sv =====
module stc_sweep_calc (
    input  logic [11:0] shadow,
    input  logic [2:0]  shift,
    input  logic        negate,
    output logic [12:0] target,
    output logic        overflow
);
    import stc_pkg::*;

    logic [11:0] delta;
    logic [12:0] diff;

    assign delta = shadow >> shift;
    assign diff  = {1'b0, shadow - delta};

    always_comb
    begin
        if (negate)
        begin
            target = diff;
        end
        else
        begin
            target = {1'b0, shadow} + {1'b0, delta};
        end
    end

    assign overflow = (target > {1'b0, FREQ_LIMIT});

endmodule

// ===== design/stc_core.sv =====
module stc_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  stc_pkg::item_t  item,
    output stc_pkg::result_t result
);
    import stc_pkg::*;

    logic [2:0]  sweep_period_reg, sweep_period_next;
    logic        sweep_negate_reg, sweep_negate_next;
    logic [2:0]  sweep_shift_reg, sweep_shift_next;
    logic [2:0]  sweep_countdown_reg, sweep_countdown_next;
    logic        sweep_active_reg, sweep_active_next;
    logic [11:0] shadow_frequency_reg, shadow_frequency_next;
    logic [3:0]  volume_reg, volume_next;
    logic [3:0]  initial_volume_reg, initial_volume_next;
    logic        envelope_raise_reg, envelope_raise_next;
    logic [2:0]  envelope_period_reg, envelope_period_next;
    logic [2:0]  envelope_countdown_reg, envelope_countdown_next;
    logic        envelope_stopped_reg, envelope_stopped_next;
    logic [1:0]  duty_select_reg, duty_select_next;
    logic [10:0] frequency_reg, frequency_next;
    logic [6:0]  length_count_reg, length_count_next;
    logic        length_enable_reg, length_enable_next;
    logic        enabled_reg, enabled_next;
    logic [13:0] period_countdown_reg, period_countdown_next;
    logic [2:0]  duty_position_reg, duty_position_next;
    logic [3:0]  output_level_reg, output_level_next;

    logic [12:0] clk_target;
    logic        clk_overflow;
    logic [12:0] chk_target;
    logic        chk_overflow;
    logic [12:0] trig_target;
    logic        trig_overflow;
    logic [10:0] freq_written;

    assign freq_written = {item.data[2:0], frequency_reg[7:0]};

    stc_sweep_calc u_sweep_clk (
        .shadow   (shadow_frequency_reg),
        .shift    (sweep_shift_reg),
        .negate   (sweep_negate_reg),
        .target   (clk_target),
        .overflow (clk_overflow)
    );

    stc_sweep_calc u_sweep_chk (
        .shadow   (clk_target[11:0]),
        .shift    (sweep_shift_reg),
        .negate   (sweep_negate_reg),
        .target   (chk_target),
        .overflow (chk_overflow)
    );

    stc_sweep_calc u_sweep_trig (
        .shadow   ({1'b0, freq_written}),
        .shift    (sweep_shift_reg),
        .negate   (sweep_negate_reg),
        .target   (trig_target),
        .overflow (trig_overflow)
    );

    always_comb
    begin
        logic [4:0] vol5;
        logic [7:0] rd;

        vol5 = 5'd0;
        rd   = 8'd0;

        sweep_period_next       = sweep_period_reg;
        sweep_negate_next       = sweep_negate_reg;
        sweep_shift_next        = sweep_shift_reg;
        sweep_countdown_next    = sweep_countdown_reg;
        sweep_active_next       = sweep_active_reg;
        shadow_frequency_next   = shadow_frequency_reg;
        volume_next             = volume_reg;
        initial_volume_next     = initial_volume_reg;
        envelope_raise_next     = envelope_raise_reg;
        envelope_period_next    = envelope_period_reg;
        envelope_countdown_next = envelope_countdown_reg;
        envelope_stopped_next   = envelope_stopped_reg;
        duty_select_next        = duty_select_reg;
        frequency_next          = frequency_reg;
        length_count_next       = length_count_reg;
        length_enable_next      = length_enable_reg;
        enabled_next            = enabled_reg;
        period_countdown_next   = period_countdown_reg;
        duty_position_next      = duty_position_reg;
        output_level_next       = output_level_reg;

        case (item.cmd)
            CMD_WRITE:
            begin
                case (item.offset)
                    OFF_SWEEP:
                    begin
                        sweep_shift_next  = item.data[2:0];
                        sweep_negate_next = item.data[3];
                        sweep_period_next = item.data[6:4];
                    end
                    OFF_DUTY:
                    begin
                        length_count_next = LENGTH_FULL - {1'b0, item.data[5:0]};
                        duty_select_next  = item.data[7:6];
                    end
                    OFF_ENVELOPE:
                    begin
                        vol5 = {1'b0, volume_reg};
                        if (envelope_period_reg == 3'd0 && !envelope_stopped_reg)
                        begin
                            vol5 = vol5 + 5'd1;
                        end
                        else if (!envelope_raise_reg)
                        begin
                            vol5 = vol5 + 5'd2;
                        end
                        if (item.data[3] != envelope_raise_reg)
                        begin
                            vol5 = 5'd16 - {1'b0, vol5[3:0]};
                        end
                        volume_next          = vol5[3:0];
                        envelope_period_next = item.data[2:0];
                        envelope_raise_next  = item.data[3];
                        initial_volume_next  = item.data[7:4];
                        if (item.data[7:3] == 5'd0)
                        begin
                            enabled_next = 1'b0;
                        end
                    end
                    OFF_FREQ_LO:
                    begin
                        frequency_next = {frequency_reg[10:8], item.data};
                    end
                    OFF_FREQ_HI:
                    begin
                        frequency_next = freq_written;
                        if (item.data[7])
                        begin
                            enabled_next = envelope_raise_reg || (initial_volume_reg != 4'd0);
                            period_countdown_next = period_reload(freq_written);
                            if (length_count_reg == 7'd0)
                            begin
                                length_count_next = LENGTH_FULL;
                            end
                            envelope_countdown_next = envelope_period_reg;
                            envelope_stopped_next   = 1'b0;
                            volume_next             = initial_volume_reg;
                            shadow_frequency_next   = {1'b0, freq_written};
                            sweep_countdown_next    = sweep_period_reg;
                            sweep_active_next       = (sweep_period_reg != 3'd0) ||
                                                      (sweep_shift_reg != 3'd0);
                            if (sweep_shift_reg != 3'd0)
                            begin
                                shadow_frequency_next = trig_target[11:0];
                                if (trig_overflow)
                                begin
                                    sweep_active_next = 1'b0;
                                    enabled_next      = 1'b0;
                                end
                            end
                        end
                        length_enable_next = item.data[6];
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_READ:
            begin
                case (item.offset)
                    OFF_SWEEP:    rd = {1'b0, sweep_period_reg, sweep_negate_reg,
                                        sweep_shift_reg};
                    OFF_DUTY:     rd = {duty_select_reg, 6'd0};
                    OFF_ENVELOPE: rd = {initial_volume_reg, envelope_raise_reg,
                                        envelope_period_reg};
                    OFF_FREQ_HI:  rd = {1'b0, length_enable_reg, 6'd0};
                    default:      rd = 8'd0;
                endcase
                rd = rd | open_bus(item.offset);
            end
            CMD_TICK:
            begin
                if (enabled_reg && DUTY_TABLE[duty_select_reg][duty_position_reg])
                begin
                    output_level_next = volume_reg;
                end
                else
                begin
                    output_level_next = 4'd0;
                end
                if (period_countdown_reg <= 14'd1)
                begin
                    period_countdown_next = period_reload(frequency_reg);
                    duty_position_next    = duty_position_reg + 3'd1;
                end
                else
                begin
                    period_countdown_next = period_countdown_reg - 14'd1;
                end
            end
            CMD_SWEEP:
            begin
                if (sweep_active_reg && sweep_countdown_reg != 3'd0 &&
                    sweep_period_reg != 3'd0)
                begin
                    sweep_countdown_next = sweep_countdown_reg - 3'd1;
                    if (sweep_countdown_reg == 3'd1)
                    begin
                        sweep_countdown_next = sweep_period_reg;
                        if (clk_overflow)
                        begin
                            sweep_active_next = 1'b0;
                            enabled_next      = 1'b0;
                        end
                        else if (sweep_shift_reg != 3'd0)
                        begin
                            shadow_frequency_next = clk_target[11:0];
                            frequency_next        = clk_target[10:0];
                            if (chk_overflow)
                            begin
                                sweep_active_next = 1'b0;
                                enabled_next      = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_LENGTH:
            begin
                if (length_enable_reg && length_count_reg != 7'd0)
                begin
                    length_count_next = length_count_reg - 7'd1;
                    if (length_count_reg == 7'd1)
                    begin
                        enabled_next = 1'b0;
                    end
                end
            end
            CMD_ENVELOPE:
            begin
                if (envelope_countdown_reg != 3'd0 && !envelope_stopped_reg)
                begin
                    envelope_countdown_next = envelope_countdown_reg - 3'd1;
                    if (envelope_countdown_reg == 3'd1)
                    begin
                        if (envelope_raise_reg && volume_reg != 4'd15)
                        begin
                            volume_next = volume_reg + 4'd1;
                        end
                        else if (!envelope_raise_reg && volume_reg != 4'd0)
                        begin
                            volume_next = volume_reg - 4'd1;
                        end
                        else
                        begin
                            envelope_stopped_next = 1'b1;
                        end
                        envelope_countdown_next = envelope_period_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.read_byte    = rd;
        result.sample_level = enabled_next ? output_level_next : 4'd0;
        result.channel_on   = enabled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_period_reg       <= '0;
            sweep_negate_reg       <= 1'b0;
            sweep_shift_reg        <= '0;
            sweep_countdown_reg    <= '0;
            sweep_active_reg       <= 1'b0;
            shadow_frequency_reg   <= '0;
            volume_reg             <= '0;
            initial_volume_reg     <= '0;
            envelope_raise_reg     <= 1'b0;
            envelope_period_reg    <= '0;
            envelope_countdown_reg <= '0;
            envelope_stopped_reg   <= 1'b0;
            duty_select_reg        <= '0;
            frequency_reg          <= '0;
            length_count_reg       <= '0;
            length_enable_reg      <= 1'b0;
            enabled_reg            <= 1'b0;
            period_countdown_reg   <= '0;
            duty_position_reg      <= '0;
            output_level_reg       <= '0;
        end
        else if (step)
        begin
            sweep_period_reg       <= sweep_period_next;
            sweep_negate_reg       <= sweep_negate_next;
            sweep_shift_reg        <= sweep_shift_next;
            sweep_countdown_reg    <= sweep_countdown_next;
            sweep_active_reg       <= sweep_active_next;
            shadow_frequency_reg   <= shadow_frequency_next;
            volume_reg             <= volume_next;
            initial_volume_reg     <= initial_volume_next;
            envelope_raise_reg     <= envelope_raise_next;
            envelope_period_reg    <= envelope_period_next;
            envelope_countdown_reg <= envelope_countdown_next;
            envelope_stopped_reg   <= envelope_stopped_next;
            duty_select_reg        <= duty_select_next;
            frequency_reg          <= frequency_next;
            length_count_reg       <= length_count_next;
            length_enable_reg      <= length_enable_next;
            enabled_reg            <= enabled_next;
            period_countdown_reg   <= period_countdown_next;
            duty_position_reg      <= duty_position_next;
            output_level_reg       <= output_level_next;
        end
    end

    a_length_expire: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.cmd == CMD_LENGTH && length_enable_reg && length_count_reg == 7'd1
        |=> !enabled_reg)
        else $error("length expiry left channel on");

    a_trigger_volume: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.cmd == CMD_WRITE && item.offset == OFF_FREQ_HI && item.data[7]
        |=> volume_reg == $past(initial_volume_reg))
        else $error("trigger did not reload volume");

    a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && item.cmd == CMD_TICK) |=> $stable(duty_position_reg))
        else $error("duty position moved without tick");

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        period_countdown_reg <= PERIOD_MAX)
        else $error("period countdown out of range");

endmodule

// ===== design/square_tone_channel_with_sweep.sv =====
// Channel  | Handshake                  | Word
// item     | item_valid / item_ready    | command, reg_offset, write_byte
// result   | result_valid / result_ready| read_byte, sample_level, channel_on
//
// One word per cycle if results flow; a word crosses the input, then the result register.
// The input register feeds the channel update logic, which writes the result register.
// Reset clears all channel state and both valid flags.
// A stalled result holds the input register; the next word is still taken once it moves.
module square_tone_channel_with_sweep (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [2:0] command,
    input  logic [2:0] reg_offset,
    input  logic [7:0] write_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] read_byte,
    output logic [3:0] sample_level,
    output logic       channel_on
);
    import stc_pkg::*;

    logic    item_vld_reg, item_vld_next;
    item_t   item_reg;
    logic    res_vld_reg, res_vld_next;
    result_t res_reg;
    result_t core_result;
    logic    advance;
    logic    take;

    assign advance    = item_vld_reg && (!res_vld_reg || result_ready);
    assign item_ready = !item_vld_reg || advance;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        item_vld_next = take || (item_vld_reg && !advance);
        res_vld_next  = advance || (res_vld_reg && !result_ready);
    end

    stc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{cmd: cmd_t'(command), offset: reg_offset, data: write_byte};
        end
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign result_valid = res_vld_reg;
    assign read_byte    = res_reg.read_byte;
    assign sample_level = res_reg.sample_level;
    assign channel_on   = res_reg.channel_on;

endmodule

// ===== tb/tb_square_tone_channel_with_sweep.sv =====
module tb_square_tone_channel_with_sweep;
    import stc_pkg::*;

    localparam logic [2:0] CMD_SPARE_A  = 3'd6;
    localparam logic [2:0] CMD_SPARE_B  = 3'd7;
    localparam logic [2:0] OFF_SPARE_LO = 3'd5;
    localparam logic [2:0] OFF_SPARE_HI = 3'd7;

    localparam int TARGET_WORDS  = 950;
    localparam int CALM_WORDS    = 120;
    localparam int LONG_HOLD     = 150;
    localparam int HOLD_AT_WORD  = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] offset;
        logic [7:0] data;
        logic       drain_first;
    } word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [2:0] command = 3'd0;
    logic [2:0] reg_offset = 3'd0;
    logic [7:0] write_byte = 8'd0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] read_byte;
    logic [3:0] sample_level;
    logic       channel_on;

    square_tone_channel_with_sweep dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .reg_offset   (reg_offset),
        .write_byte   (write_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_byte    (read_byte),
        .sample_level (sample_level),
        .channel_on   (channel_on)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // channel state mirror
    logic [2:0]  sw_period = '0, sw_shift = '0, sw_count = '0;
    logic        sw_negate = 1'b0, sw_active = 1'b0;
    logic [11:0] shadow_freq = '0;
    logic [3:0]  vol = '0, vol_init = '0, level = '0;
    logic        env_raise = 1'b0, env_stopped = 1'b0;
    logic [2:0]  env_period = '0, env_count = '0;
    logic [1:0]  duty_sel = '0;
    logic [10:0] freq = '0;
    logic [6:0]  len_count = '0;
    logic        len_enable = 1'b0, chan_enabled = 1'b0;
    logic [13:0] period_count = '0;
    logic [2:0]  duty_pos = '0;

    word_t   send_q[$];
    result_t channel_outputs_q[$];
    word_t   next_word;
    result_t expected_out;

    int total_words = 0, useful_words = 0;
    int words_in = 0, words_out = 0, mismatches = 0;
    int n_writes = 0, n_triggers = 0, n_reads = 0, n_ticks = 0, n_frame = 0, n_spare = 0;
    int n_on = 0;
    int send_gap = 0, stall_left = 0, hold_left = 0;
    logic hold_done = 1'b0, word_taken = 1'b0;

    function automatic logic [12:0] sweep_next_freq();
        logic [11:0] step;
        step = shadow_freq >> sw_shift;
        if (sw_negate)
            return {1'b0, shadow_freq - step};
        return {1'b0, shadow_freq} + {1'b0, step};
    endfunction

    function automatic logic [13:0] timer_reload(input logic [10:0] f);
        int span;
        span = (2048 - int'(f)) * 4;
        return span[13:0];
    endfunction

    function automatic int idle_chance(input int phase);
        case (phase % 3)
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    task automatic advance_channel(input logic [2:0] cmd, input logic [2:0] off,
                                   input logic [7:0] data, output result_t r);
        logic [12:0] target;
        logic [7:0]  pattern, rd;
        int          v;
        rd = 8'h00;
        case (cmd)
            CMD_WRITE:
            begin
                n_writes++;
                case (off)
                    OFF_SWEEP:
                    begin
                        sw_shift = data[2:0];
                        sw_negate = data[3];
                        sw_period = data[6:4];
                    end
                    OFF_DUTY:
                    begin
                        len_count = 7'd64 - {1'b0, data[5:0]};
                        duty_sel = data[7:6];
                    end
                    OFF_ENVELOPE:
                    begin
                        v = vol;
                        if (env_period == 0 && !env_stopped)
                            v = v + 1;
                        else if (!env_raise)
                            v = v + 2;
                        if (data[3] != env_raise)
                            v = 16 - (v & 15);
                        vol = v[3:0];
                        env_period = data[2:0];
                        env_raise = data[3];
                        vol_init = data[7:4];
                        if (data[7:3] == 5'd0)
                            chan_enabled = 1'b0;
                    end
                    OFF_FREQ_LO:
                        freq = {freq[10:8], data};
                    OFF_FREQ_HI:
                    begin
                        freq = {data[2:0], freq[7:0]};
                        if (data[7])
                        begin
                            n_triggers++;
                            chan_enabled = env_raise || vol_init != 0;
                            period_count = timer_reload(freq);
                            if (len_count == 0)
                                len_count = 7'd64;
                            env_count = env_period;
                            env_stopped = 1'b0;
                            vol = vol_init;
                            shadow_freq = {1'b0, freq};
                            sw_count = sw_period;
                            sw_active = sw_period != 0 || sw_shift != 0;
                            if (sw_shift != 0)
                            begin
                                target = sweep_next_freq();
                                shadow_freq = target[11:0];
                                if (target > 13'd2047)
                                begin
                                    sw_active = 1'b0;
                                    chan_enabled = 1'b0;
                                end
                            end
                        end
                        len_enable = data[6];
                    end
                    default: ;
                endcase
            end
            CMD_READ:
            begin
                n_reads++;
                case (off)
                    OFF_SWEEP:    rd = 8'h80 | {1'b0, sw_period, sw_negate, sw_shift};
                    OFF_DUTY:     rd = 8'h3F | {duty_sel, 6'd0};
                    OFF_ENVELOPE: rd = {vol_init, env_raise, env_period};
                    OFF_FREQ_LO:  rd = 8'hFF;
                    OFF_FREQ_HI:  rd = 8'hBF | {1'b0, len_enable, 6'd0};
                    default:      rd = 8'hFF;
                endcase
            end
            CMD_TICK:
            begin
                n_ticks++;
                case (duty_sel)
                    2'd0: pattern = 8'h01;
                    2'd1: pattern = 8'h81;
                    2'd2: pattern = 8'h87;
                    default: pattern = 8'h7E;
                endcase
                level = (chan_enabled && pattern[duty_pos]) ? vol : 4'd0;
                if (period_count <= 14'd1)
                begin
                    period_count = timer_reload(freq);
                    duty_pos = duty_pos + 3'd1;
                end
                else
                    period_count = period_count - 14'd1;
            end
            CMD_SWEEP:
            begin
                n_frame++;
                if (sw_active && sw_count != 0 && sw_period != 0)
                begin
                    sw_count = sw_count - 3'd1;
                    if (sw_count == 0)
                    begin
                        sw_count = sw_period;
                        target = sweep_next_freq();
                        if (target > 13'd2047)
                        begin
                            sw_active = 1'b0;
                            chan_enabled = 1'b0;
                        end
                        else if (sw_shift != 0)
                        begin
                            shadow_freq = target[11:0];
                            freq = target[10:0];
                            if (sweep_next_freq() > 13'd2047)
                            begin
                                sw_active = 1'b0;
                                chan_enabled = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_LENGTH:
            begin
                n_frame++;
                if (len_enable && len_count != 0)
                begin
                    len_count = len_count - 7'd1;
                    if (len_count == 0)
                        chan_enabled = 1'b0;
                end
            end
            CMD_ENVELOPE:
            begin
                n_frame++;
                if (env_count != 0 && !env_stopped)
                begin
                    env_count = env_count - 3'd1;
                    if (env_count == 0)
                    begin
                        if (env_raise && vol < 4'd15)
                            vol = vol + 4'd1;
                        else if (!env_raise && vol > 4'd0)
                            vol = vol - 4'd1;
                        else
                            env_stopped = 1'b1;
                        env_count = env_period;
                    end
                end
            end
            default:
                n_spare++;
        endcase
        r.read_byte = rd;
        r.sample_level = chan_enabled ? level : 4'd0;
        r.channel_on = chan_enabled;
    endtask

    task automatic push_word(input logic [2:0] cmd, input logic [2:0] off,
                             input logic [7:0] data, input logic drain);
        word_t w;
        w.cmd = cmd;
        w.offset = off;
        w.data = data;
        w.drain_first = drain;
        send_q.push_back(w);
        if (cmd <= CMD_ENVELOPE && !(cmd == CMD_WRITE && off > OFF_FREQ_HI))
            useful_words++;
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR: %s", msg);
    endtask

    // sender: hold an offered word until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (item_valid && !word_taken)
            item_valid <= 1'b1;
        else if (send_gap != 0)
        begin
            item_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (send_q.size() != 0 && (!send_q[0].drain_first || words_out == words_in))
        begin
            if (hold_left == 0 && words_in + CALM_WORDS < total_words
                && $urandom_range(0, 99) < idle_chance(words_in / 80))
            begin
                item_valid <= 1'b0;
                send_gap <= $urandom_range(0, 13);
            end
            else
            begin
                next_word = send_q.pop_front();
                item_valid <= 1'b1;
                command <= next_word.cmd;
                reg_offset <= next_word.offset;
                write_byte <= next_word.data;
            end
        end
        else
            item_valid <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && words_in >= HOLD_AT_WORD)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_left != 0)
            result_ready <= 1'b0;
        else if (stall_left != 0)
        begin
            result_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (words_in + CALM_WORDS < total_words
                 && $urandom_range(0, 99) < idle_chance(words_in / 80 + 1))
        begin
            result_ready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            word_taken <= item_valid && item_ready;
            if (item_valid && item_ready)
            begin
                advance_channel(command, reg_offset, write_byte, expected_out);
                channel_outputs_q.push_back(expected_out);
                words_in++;
            end
            if (result_valid && result_ready)
            begin
                if (channel_outputs_q.size() == 0)
                    log_mismatch($sformatf("unexpected result %h %h %b",
                                           read_byte, sample_level, channel_on));
                else
                begin
                    expected_out = channel_outputs_q.pop_front();
                    if (read_byte !== expected_out.read_byte
                        || sample_level !== expected_out.sample_level
                        || channel_on !== expected_out.channel_on)
                        log_mismatch({$sformatf("result %0d: read_byte exp %h got %h, ",
                                                words_out, expected_out.read_byte,
                                                read_byte),
                                      $sformatf("sample_level exp %h got %h, ",
                                                expected_out.sample_level,
                                                sample_level),
                                      $sformatf("channel_on exp %b got %b",
                                                expected_out.channel_on, channel_on)});
                    if (expected_out.channel_on)
                        n_on++;
                end
                words_out++;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timed out with %0d of %0d words taken, %0d results", words_in,
                 total_words, words_out);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int          r, seq;
        logic [7:0]  b;
        logic        drain;

        push_word(CMD_TICK, OFF_SWEEP, 8'h00, 1'b0);
        push_word(CMD_READ, OFF_SWEEP, 8'h00, 1'b0);
        push_word(CMD_WRITE, OFF_SWEEP, 8'hFF, 1'b0);
        push_word(CMD_WRITE, OFF_DUTY, 8'hFF, 1'b0);
        push_word(CMD_WRITE, OFF_ENVELOPE, 8'hFF, 1'b0);
        push_word(CMD_WRITE, OFF_FREQ_LO, 8'hFF, 1'b0);
        push_word(CMD_WRITE, OFF_FREQ_HI, 8'hC7, 1'b0);
        push_word(CMD_READ, OFF_SWEEP, 8'hFF, 1'b0);
        push_word(CMD_READ, OFF_DUTY, 8'hFF, 1'b0);
        push_word(CMD_READ, OFF_ENVELOPE, 8'hFF, 1'b0);
        push_word(CMD_READ, OFF_FREQ_LO, 8'hFF, 1'b0);
        push_word(CMD_READ, OFF_FREQ_HI, 8'hFF, 1'b0);
        push_word(CMD_TICK, OFF_FREQ_HI, 8'h00, 1'b0);
        push_word(CMD_SWEEP, OFF_SWEEP, 8'h00, 1'b0);
        push_word(CMD_ENVELOPE, OFF_ENVELOPE, 8'h00, 1'b0);
        push_word(CMD_LENGTH, OFF_DUTY, 8'h00, 1'b0);
        push_word(CMD_SPARE_A, OFF_SWEEP, 8'hFF, 1'b0);
        push_word(CMD_SPARE_B, OFF_SPARE_HI, 8'h00, 1'b0);
        push_word(CMD_READ, OFF_SPARE_LO, 8'h00, 1'b0);
        push_word(CMD_WRITE, OFF_SPARE_HI, 8'h00, 1'b0);
        push_word(CMD_WRITE, OFF_ENVELOPE, 8'h00, 1'b0);
        push_word(CMD_WRITE, OFF_SWEEP, 8'h10, 1'b0);
        push_word(CMD_WRITE, OFF_ENVELOPE, 8'hF0, 1'b0);
        push_word(CMD_WRITE, OFF_FREQ_HI, 8'h87, 1'b0);
        push_word(CMD_ENVELOPE, OFF_SWEEP, 8'h00, 1'b0);
        push_word(CMD_SWEEP, OFF_SWEEP, 8'h00, 1'b0);

        seq = 0;
        while (useful_words < TARGET_WORDS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                drain = (seq % 25 == 0);
                push_word(CMD_WRITE, OFF_SWEEP, 8'($urandom_range(0, 255)), drain);
                push_word(CMD_WRITE, OFF_DUTY, 8'($urandom_range(0, 255)), 1'b0);
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 4) != 0)
                    b[7:4] = 4'($urandom_range(1, 15));
                push_word(CMD_WRITE, OFF_ENVELOPE, b, 1'b0);
                b = $urandom_range(0, 1) ? 8'($urandom_range(8'hF0, 8'hFF))
                                         : 8'($urandom_range(0, 255));
                push_word(CMD_WRITE, OFF_FREQ_LO, b, 1'b0);
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 6) != 0)
                    b[7] = 1'b1;
                if ($urandom_range(0, 3) != 0)
                    b[2:0] = 3'd7;
                push_word(CMD_WRITE, OFF_FREQ_HI, b, 1'b0);
                repeat ($urandom_range(15, 45))
                begin
                    r = $urandom_range(0, 99);
                    b = 8'($urandom_range(0, 255));
                    if (r < 55)
                        push_word(CMD_TICK, 3'($urandom_range(0, 7)), b, 1'b0);
                    else if (r < 65)
                        push_word(CMD_SWEEP, 3'($urandom_range(0, 7)), b, 1'b0);
                    else if (r < 75)
                        push_word(CMD_LENGTH, 3'($urandom_range(0, 7)), b, 1'b0);
                    else if (r < 85)
                        push_word(CMD_ENVELOPE, 3'($urandom_range(0, 7)), b, 1'b0);
                    else if (r < 92)
                        push_word(CMD_READ, 3'($urandom_range(0, 7)), b, 1'b0);
                    else
                        push_word(CMD_WRITE, 3'($urandom_range(0, 4)), b, 1'b0);
                end
                seq++;
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    push_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)), 1'b0);
            end
        end
        total_words = send_q.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (words_in == total_words);
        wait (words_out == words_in);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (channel_outputs_q.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", channel_outputs_q.size()));

        $write("Covered %0d words: %0d writes (%0d triggers), %0d reads, ",
               words_in, n_writes, n_triggers, n_reads);
        $display("%0d ticks, %0d frame clocks, %0d spare", n_ticks, n_frame, n_spare);
        $display("Checked %0d results, %0d with the channel on, %0d mismatches",
                 words_out, n_on, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
